/* rtl/sig_pkg.sv */
// Shared constants, codes and result type for the sorted intersection block.
package sig_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int VALUE_W_DEF = 32;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 10;
    localparam int MODE_W      = 2;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROBE  = 2'd2;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  pos;
    } t_res;

endpackage

/* rtl/sig_mem.sv */
// Element store: one write port, one read port with registered read data.
module sig_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sig_engine.sv */
// Command decoder and gallop/bisect sequencer driving the element store.
module sig_engine #(
    parameter int STORE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [sig_pkg::MODE_W-1:0]      i_mode,
    input  logic signed [sig_pkg::DATA_W-1:0] i_item_value,
    input  logic                            i_last_probe,
    output logic                            o_we,
    output logic [AW-1:0]                   o_waddr,
    output logic [VALUE_WIDTH-1:0]          o_wdata,
    output logic                            o_re,
    output logic [AW-1:0]                   o_raddr,
    input  logic [VALUE_WIDTH-1:0]          i_rdata,
    output logic                            o_push,
    output sig_pkg::t_res                   o_res,
    input  logic                            i_slot_free
);

    import sig_pkg::*;

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int SW = CW + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAL,
        S_BSET,
        S_BCHK,
        S_BIS,
        S_FIN,
        S_PUSH
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_sp, n_sp;
    logic signed [VALUE_WIDTH-1:0] r_key, n_key;
    logic                    r_last, n_last;
    logic [SW-1:0]           r_start, n_start;
    logic [SW-1:0]           r_stride, n_stride;
    logic [SW-1:0]           r_lo, n_lo;
    logic [SW-1:0]           r_hi, n_hi;
    logic [SW-1:0]           r_mid, n_mid;
    t_res                    r_res, n_res;

    logic signed [VALUE_WIDTH-1:0] w_val;
    logic signed [VALUE_WIDTH-1:0] w_rdata;
    logic [SW-1:0]           w_n;
    logic [SW-1:0]           w_last_idx;
    logic [SW-1:0]           w_sp;
    logic [SW-1:0]           w_raddr;
    logic [SW-1:0]           w_top;
    logic                    w_hit;

    assign w_val      = VALUE_WIDTH'(i_item_value);
    assign w_rdata    = i_rdata;
    assign w_n        = SW'(r_count);
    assign w_last_idx = w_n - SW'(1);
    assign w_sp       = SW'(r_sp);
    assign w_top      = r_start + r_stride;
    assign w_hit      = (w_rdata == r_key);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_sp     = r_sp;
        n_key    = r_key;
        n_last   = r_last;
        n_start  = r_start;
        n_stride = r_stride;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_res    = r_res;
        o_we     = 1'b0;
        o_waddr  = r_count[AW-1:0];
        o_wdata  = w_val;
        o_re     = 1'b0;
        w_raddr  = '0;
        o_push   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_mode)
                        MODE_CLEAR: begin
                            n_count = '0;
                            n_sp    = '0;
                        end
                        MODE_APPEND: begin
                            // drop appends once the store is full
                            if (r_count < CW'(STORE_DEPTH)) begin
                                o_we    = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        MODE_PROBE: begin
                            n_key  = w_val;
                            n_last = i_last_probe;
                            if (r_count == '0) begin
                                n_sp    = '0;
                                n_res   = '0;
                                n_state = S_PUSH;
                            end else begin
                                n_start  = (w_sp >= w_n) ? w_last_idx : w_sp;
                                n_stride = SW'(1);
                                w_raddr  = n_start + SW'(1);
                                if (w_raddr < w_n) begin
                                    o_re    = 1'b1;
                                    n_state = S_GAL;
                                end else begin
                                    n_state = S_BSET;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_GAL: begin
                if (w_rdata < r_key) begin
                    n_stride = r_stride << 1;
                    w_raddr  = r_start + n_stride;
                    if (w_raddr < w_n) begin
                        o_re = 1'b1;
                    end else begin
                        n_state = S_BSET;
                    end
                end else begin
                    n_state = S_BSET;
                end
            end
            S_BSET: begin
                n_lo    = r_start + (r_stride >> 1);
                n_hi    = (w_top > w_last_idx) ? w_last_idx : w_top;
                n_state = S_BCHK;
            end
            S_BCHK: begin
                o_re = 1'b1;
                if (r_lo < r_hi) begin
                    n_mid   = r_lo + ((r_hi - r_lo) >> 1);
                    w_raddr = n_mid;
                    n_state = S_BIS;
                end else begin
                    w_raddr = r_lo;
                    n_state = S_FIN;
                end
            end
            S_BIS: begin
                if (w_rdata < r_key) begin
                    n_lo = r_mid + SW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_BCHK;
            end
            S_FIN: begin
                n_res.found = w_hit;
                n_res.value = w_hit ? DATA_W'(r_key) : '0;
                n_res.pos   = POS_W'(r_lo[AW-1:0]);
                n_sp        = r_last ? '0 : r_lo[AW-1:0];
                n_state     = S_PUSH;
            end
            S_PUSH: begin
                o_push = 1'b1;
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_raddr = w_raddr[AW-1:0];
    assign o_ready = (r_state == S_IDLE);
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sp    <= n_sp;
        end
        r_key    <= n_key;
        r_last   <= n_last;
        r_start  <= n_start;
        r_stride <= n_stride;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_res    <= n_res;
    end

endmodule

/* rtl/sorted_intersection_galloping.sv */
// Top level: sorted set intersection by galloping search over a stored array.
//
// Input channel (i_valid/o_ready) carries one command per transfer: mode 0
// clears the store, mode 1 appends item_value at the end (dropped when the
// store is full), mode 2 probes item_value. Mode 3 is taken and ignored.
// Clear and append give no result.
// Each probe gives exactly one result on the output channel (o_valid/i_ready):
// found, the probe value when found (else zero), and the index of the first
// stored element not below the probe, searched from the index where the previous
// probe ended (the last index when none is found). A probe with last_probe
// set returns the start index of the next probe to zero. A probe occupies
// the sequencer through its gallop steps and then its bisection steps; the
// single read port of the element store makes one read per step.
// An empty store answers a probe with a miss at index zero.
// One output register decouples the sides: a new command is taken while a
// result waits; a probe that finishes while the receiver stalls holds until
// the register drains. Reset empties the store and the output register.
module sorted_intersection_galloping #(
    parameter int STORE_DEPTH = sig_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = sig_pkg::VALUE_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [sig_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [sig_pkg::DATA_W-1:0] i_item_value,
    input  logic                              i_last_probe,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_found,
    output logic signed [sig_pkg::DATA_W-1:0] o_matched_value,
    output logic [sig_pkg::POS_W-1:0]         o_match_position
);

    import sig_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;
    logic [VALUE_WIDTH-1:0] w_rdata;
    logic                   w_push;
    t_res                   w_res;
    logic                   w_slot_free;

    logic                   r_out_valid;
    t_res                   r_out;

    sig_mem #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sig_engine #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_item_value (i_item_value),
        .i_last_probe (i_last_probe),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_re         (w_re),
        .o_raddr      (w_raddr),
        .i_rdata      (w_rdata),
        .o_push       (w_push),
        .o_res        (w_res),
        .i_slot_free  (w_slot_free)
    );

    // slot frees when empty or draining this cycle
    assign w_slot_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid <= w_push;
        end
        if (w_slot_free && w_push) begin
            r_out <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_found          = r_out.found;
    assign o_matched_value  = $signed(r_out.value);
    assign o_match_position = r_out.pos;

endmodule

/* rtl/sig_checker.sv */
// Port-level checker for the sorted intersection block, bound to the top level.
module sig_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic [sig_pkg::MODE_W-1:0]        i_mode,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic                              o_found,
    input logic signed [sig_pkg::DATA_W-1:0] o_matched_value,
    input logic [sig_pkg::POS_W-1:0]         o_match_position
);

    import sig_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found)
            && $stable(o_matched_value) && $stable(o_match_position))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_matched_value == '0)
        else $error("miss carries a nonzero value");

    // a probe keeps the sequencer busy after its transfer
    a_probe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_mode == MODE_PROBE |=> !o_ready)
        else $error("ready right after a probe transfer");

    // clear, append and unused codes finish in the cycle they are taken
    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_mode != MODE_PROBE |=> o_ready)
        else $error("busy after a non-probe transfer");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

endmodule

bind sorted_intersection_galloping sig_checker u_sig_checker (.*);

/* sim/tb_sorted_intersection_galloping.sv */
// Self-checking testbench for the galloping sorted set intersection block.
module tb_sorted_intersection_galloping;
    import sig_pkg::*;

    localparam int CAPACITY     = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int FULL_STEP    = 4000000;

    localparam logic [MODE_W-1:0]        MODE_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MIN     = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX     = 32'sh7fff_ffff;

    typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_PERIODIC} t_stall;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     typed;
        t_res                     res;
    } t_cmd;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [MODE_W-1:0]        i_mode;
    logic signed [DATA_W-1:0] i_item_value;
    logic                     i_last_probe;
    logic                     o_valid;
    logic                     i_ready;
    logic                     o_found;
    logic signed [DATA_W-1:0] o_matched_value;
    logic [POS_W-1:0]         o_match_position;

    // expectation typed into the table travels with the payload
    logic drv_typed;
    t_res drv_res;

    // mirror of the block state
    logic signed [DATA_W-1:0] mirror_store [CAPACITY];
    int mirror_count = 0;
    int mirror_start = 0;

    t_res lookup_q [$];
    logic signed [DATA_W-1:0] gen_vals [$];

    int bad_count    = 0;
    int probe_count  = 0;
    int hit_count    = 0;
    int drop_count   = 0;
    int result_count = 0;
    int sent_count   = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;
    bit hold_req     = 1'b0;
    bit hold_used    = 1'b0;

    // directed rows; res is only meaningful where typed is set
    t_cmd dir_rows [21] = '{
        '{MODE_PROBE,  32'sh0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0000_0000, 10'd0}},
        '{MODE_UNUSED, 32'sh5a5a_5a5a, 1'b1, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_APPEND, 32'sh8000_0000, 1'b1, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_APPEND, -32'sd5,        1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_APPEND, 32'sh0000_0000, 1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_APPEND, 32'sd7,         1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_APPEND, 32'sh7fff_ffff, 1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_PROBE,  32'sh8000_0000, 1'b0, 1'b1, '{1'b1, 32'h8000_0000, 10'd0}},
        '{MODE_PROBE,  32'sh0000_0000, 1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_PROBE,  32'sd3,         1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_PROBE,  -32'sd5,        1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_PROBE,  32'sh7fff_ffff, 1'b1, 1'b1, '{1'b1, 32'h7fff_ffff, 10'd4}},
        '{MODE_PROBE,  32'sd8,         1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_CLEAR,  32'shffff_ffff, 1'b1, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_PROBE,  32'shffff_ffff, 1'b0, 1'b1, '{1'b0, 32'h0000_0000, 10'd0}},
        '{MODE_APPEND, 32'sd10,        1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_APPEND, 32'sd20,        1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_PROBE,  32'sh7fff_ffff, 1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_PROBE,  32'sd10,        1'b1, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_PROBE,  32'sh8000_0000, 1'b1, 1'b0, '{1'b0, 32'h0, 10'd0}},
        '{MODE_UNUSED, 32'sh0000_0000, 1'b0, 1'b0, '{1'b0, 32'h0, 10'd0}}
    };

    sorted_intersection_galloping u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_item_value     (i_item_value),
        .i_last_probe     (i_last_probe),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_found          (o_found),
        .o_matched_value  (o_matched_value),
        .o_match_position (o_match_position)
    );

    always #1 i_clk = ~i_clk;

    // Apply one command to the mirror; returns 1 when it yields a lookup result.
    function automatic bit intersect_step(input t_cmd c, output t_res r);
        int n;
        int lo;
        int hi;
        int mid;
        int stride;
        logic signed [DATA_W-1:0] key;
        r = '0;
        key = $signed(c.value);
        n = mirror_count;
        intersect_step = 1'b0;
        if (c.mode == MODE_CLEAR) begin
            mirror_count = 0;
            mirror_start = 0;
        end else if (c.mode == MODE_APPEND) begin
            if (mirror_count < CAPACITY) begin
                mirror_store[mirror_count] = key;
                mirror_count++;
            end else begin
                drop_count++;
            end
        end else if (c.mode == MODE_PROBE) begin
            intersect_step = 1'b1;
            if (n == 0) begin
                mirror_start = 0;
            end else begin
                lo = (mirror_start >= n) ? n - 1 : mirror_start;
                stride = 1;
                // gallop forward, doubling, until an element is not below the key or the end is passed
                while (lo + stride < n && mirror_store[lo + stride] < key)
                    stride = stride * 2;
                hi = (lo + stride > n - 1) ? n - 1 : lo + stride;
                lo = lo + stride / 2;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (mirror_store[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                r.found = (mirror_store[lo] == key);
                r.value = r.found ? key : '0;
                r.pos   = lo[POS_W-1:0];
                mirror_start = c.last ? 0 : lo;
            end
        end
    endfunction

    function automatic t_cmd cmd_of(input logic [MODE_W-1:0] mode,
                                     input logic signed [DATA_W-1:0] value,
                                     input logic last);
        cmd_of = '{mode, value, last, 1'b0, '0};
    endfunction

    // Check output transfers, then fold input transfers into the mirror.
    always @(posedge i_clk) begin : check_results
        t_res got;
        t_res want;
        t_res fresh;
        t_cmd cmd;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                result_count++;
                got = '{o_found, o_matched_value, o_match_position};
                if (lookup_q.size() == 0) begin
                    $error("unexpected result: found %0d value %0h position %0d",
                           got.found, got.value, got.pos);
                    bad_count++;
                end else begin
                    want = lookup_q.pop_front();
                    if (got.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, got.found);
                        bad_count++;
                    end
                    if (got.value !== want.value) begin
                        $error("matched_value: expected %0h, actual %0h", want.value, got.value);
                        bad_count++;
                    end
                    if (got.pos !== want.pos) begin
                        $error("match_position: expected %0d, actual %0d", want.pos, got.pos);
                        bad_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                cmd = '{i_mode, i_item_value, i_last_probe, drv_typed, drv_res};
                if (intersect_step(cmd, fresh)) begin
                    probe_count++;
                    if (fresh.found)
                        hit_count++;
                    lookup_q.push_back(drv_typed ? drv_res : fresh);
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("sorted_intersection_galloping verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: changing stall styles, plus one long hold-off on request.
    initial begin
        t_stall style;
        int left;
        int period;
        int phase;
        i_ready = 1'b0;
        style  = READY_ALWAYS;
        left   = 0;
        period = 2;
        phase  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (left == 0) begin
                style  = t_stall'($urandom_range(0, 3));
                left   = $urandom_range(32, 256);
                period = $urandom_range(2, 5);
            end
            left--;
            phase++;
            case (style)
                READY_ALWAYS: i_ready <= 1'b1;
                READY_HALF:   i_ready <= ($urandom_range(0, 1) == 1);
                READY_MOSTLY: i_ready <= ($urandom_range(0, 4) != 0);
                default:      i_ready <= (phase % period == 0);
            endcase
        end
    end

    // Offer one command; bursts of random length separated by random gaps.
    task automatic send_cmd(input t_cmd c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                9:          gap = $urandom_range(5, 25);
                default:    gap = $urandom_range(1, 4);
            endcase
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_mode       <= c.mode;
        i_item_value <= c.value;
        i_last_probe <= c.last;
        drv_typed    <= c.typed;
        drv_res      <= c.res;
        do @(posedge i_clk); while (!o_ready);
        if (c.mode != MODE_UNUSED)
            sent_count++;
        // track the store contents for picking probe values
        if (c.mode == MODE_CLEAR)
            gen_vals.delete();
        else if (c.mode == MODE_APPEND && gen_vals.size() < CAPACITY)
            gen_vals.push_back(c.value);
    endtask

    // Clear, then append up to k ascending distinct values.
    task automatic fill_sorted(input int k);
        longint cur;
        longint spread;
        int i;
        logic signed [DATA_W-1:0] seed_val;
        send_cmd(cmd_of(MODE_CLEAR, $urandom, 1'($urandom_range(0, 1))));
        case ($urandom_range(0, 2))
            0:       spread = 3;
            1:       spread = 1000;
            default: spread = 1 << 20;
        endcase
        seed_val = $urandom;
        case ($urandom_range(0, 3))
            0:       cur = -64'sd2147483648;
            1:       cur = 64'sd2147483647 - k * spread;
            default: cur = seed_val;
        endcase
        for (i = 0; i < k && cur <= 64'sd2147483647; i++) begin
            send_cmd(cmd_of(MODE_APPEND, cur[DATA_W-1:0], 1'($urandom_range(0, 1))));
            cur += $urandom_range(1, spread);
        end
    endtask

    // Mostly ascending probes drawn from the store, with misses and noise.
    task automatic run_probes(input int n);
        int i;
        int idx;
        int stride;
        logic signed [DATA_W-1:0] v;
        logic last;
        idx = 0;
        stride = (gen_vals.size() > 2 * n) ? gen_vals.size() / n : 2;
        for (i = 0; i < n; i++) begin
            v = $urandom;
            if (gen_vals.size() > 0) begin
                idx += $urandom_range(0, stride);
                if (idx >= gen_vals.size())
                    idx = gen_vals.size() - 1;
                case ($urandom_range(0, 19))
                    0, 1:       ;
                    2:          v = VAL_MAX;
                    3, 4, 5, 6: v = (gen_vals[idx] == VAL_MIN) ? VAL_MIN : gen_vals[idx] - 1;
                    default:    v = gen_vals[idx];
                endcase
            end
            last = (i == n - 1) || ($urandom_range(0, 15) == 0);
            send_cmd(cmd_of(MODE_PROBE, v, last));
            if (last)
                idx = 0;
        end
    endtask

    initial begin
        int i;
        int k;
        int n;
        int base_sent;
        longint cur;
        logic signed [DATA_W-1:0] small_val;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_mode       = MODE_CLEAR;
        i_item_value = '0;
        i_last_probe = 1'b0;
        drv_typed    = 1'b0;
        drv_res      = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_cmd(dir_rows[r]);

        base_sent = sent_count;
        while (sent_count - base_sent < RANDOM_ITEMS) begin
            k = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
            n = $urandom_range(1, (2 * k + 2 > 30) ? 30 : 2 * k + 2);
            if (!hold_used && sent_count - base_sent > 250) begin
                // stall the output for a long stretch while probes keep coming
                hold_used = 1'b1;
                hold_req  = 1'b1;
                fill_sorted(30);
                run_probes(40);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        fill_sorted(k);
                        run_probes(n);
                    end
                    6: begin
                        for (i = 0; i < 10; i++)
                            send_cmd(cmd_of(MODE_W'($urandom_range(0, 3)), $urandom,
                                            1'($urandom_range(0, 1))));
                    end
                    7: begin
                        // unordered and repeated appends
                        send_cmd(cmd_of(MODE_CLEAR, $urandom, 1'($urandom_range(0, 1))));
                        for (i = 0; i < k; i++) begin
                            small_val = $urandom_range(0, 63);
                            send_cmd(cmd_of(MODE_APPEND, small_val - 32, 1'b0));
                        end
                        run_probes(n);
                    end
                    8: run_probes(n);
                    default: begin
                        send_cmd(cmd_of(MODE_CLEAR, $urandom, 1'($urandom_range(0, 1))));
                        run_probes($urandom_range(1, 3));
                    end
                endcase
            end
        end

        // full store, then appends that must be dropped
        send_cmd(cmd_of(MODE_CLEAR, '0, 1'b0));
        for (i = 0; i < CAPACITY + 2; i++) begin
            cur = -64'sd2147483648 + longint'(i) * FULL_STEP;
            send_cmd(cmd_of(MODE_APPEND, (i < CAPACITY) ? cur[DATA_W-1:0] : VAL_MAX, 1'b0));
        end
        run_probes(40);
        send_cmd(cmd_of(MODE_PROBE, VAL_MAX, 1'b0));
        send_cmd(cmd_of(MODE_PROBE, VAL_MIN, 1'b1));
        send_cmd(cmd_of(MODE_PROBE, gen_vals[CAPACITY - 1], 1'b1));

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (lookup_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d commands with %0d probes, %0d lookup results, %0d hits",
                 sent_count, probe_count, result_count, hit_count);
        $display("%0d appends dropped at a full store, one long output stall included",
                 drop_count);
        if (bad_count == 0)
            $display("sorted_intersection_galloping verification clean");
        else
            $display("sorted_intersection_galloping verification failed");
        $finish;
    end

endmodule
